// ===== rtl/tpbb_pkg.sv =====
`default_nettype none

package tpbb_pkg;

    // Geometry of the transform.
    localparam int NUM_AXES  = 3;
    localparam int NUM_LANES = 3;
    localparam int POS_FRAC  = 8;
    localparam int ROW_WIDTH = 64;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 2'd2;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Queue occupancy flags seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

// ===== rtl/tpbb_front.sv =====
`default_nettype none

module tpbb_front #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            vtx_valid,
    output logic                            vtx_stall,
    input  logic signed [COORD_WIDTH-1:0]   pos_x,
    input  logic signed [COORD_WIDTH-1:0]   pos_y,
    input  logic signed [COORD_WIDTH-1:0]   pos_z,
    input  logic                            final_vertex,
    input  tpbb_pkg::queue_status_t         q_status,
    output logic                            q_push,
    output logic [3*COORD_WIDTH:0]          q_data
);
    import tpbb_pkg::*;

    logic                     hold_valid_reg;
    logic                     hold_valid_next;
    logic [3*COORD_WIDTH:0]   hold_data_reg;
    logic                     accept;

    // The holding register stalls only while it is full and the queue is full.
    assign vtx_stall = hold_valid_reg & q_status.full;
    assign accept    = vtx_valid & ~vtx_stall;
    assign q_push    = hold_valid_reg & ~q_status.full;
    assign q_data    = hold_data_reg;

    // Occupancy of the holding register.
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Capture the request, tagged with its end-of-model flag.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_data_reg <= {final_vertex, pos_z, pos_y, pos_x};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tpbb_queue.sv =====
`default_nettype none

module tpbb_queue #(
    parameter int DATA_W = 73
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [DATA_W-1:0]           push_data,
    input  logic                        pop,
    output logic [DATA_W-1:0]           head_data,
    output tpbb_pkg::queue_status_t     status
);
    import tpbb_pkg::*;

    logic [DATA_W-1:0]        mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [QUEUE_PTR_W:0]     count_reg;
    logic [QUEUE_PTR_W:0]     count_next;

    assign status.full  = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_data    = mem_reg[rd_ptr_reg];

    // Pointer and count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tpbb_back.sv =====
`default_nettype none

module tpbb_back #(
    parameter int COORD_WIDTH = 24,
    parameter int COEFF_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tpbb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpbb_pkg::ROW_WIDTH-1:0]      cfg_data,
    input  tpbb_pkg::queue_status_t             q_status,
    input  logic [3*COORD_WIDTH:0]              q_data,
    output logic                                q_pop,
    output logic                                box_valid,
    input  logic                                box_stall,
    output logic signed [COORD_WIDTH-1:0]       lo_x,
    output logic signed [COORD_WIDTH-1:0]       lo_y,
    output logic signed [COORD_WIDTH-1:0]       lo_z,
    output logic signed [COORD_WIDTH-1:0]       hi_x,
    output logic signed [COORD_WIDTH-1:0]       hi_y,
    output logic signed [COORD_WIDTH-1:0]       hi_z
);
    import tpbb_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int CW     = COEFF_WIDTH;
    localparam int FRAC   = CW - 4;
    localparam int PROD_W = W + CW;
    localparam int SUM_W  = W + CW + 2;

    localparam logic [ROW_WIDTH-1:0] IDENT_X = ROW_WIDTH'(1) << FRAC;
    localparam logic [ROW_WIDTH-1:0] IDENT_Y = IDENT_X << CW;
    localparam logic [ROW_WIDTH-1:0] IDENT_Z = IDENT_X << (2 * CW);

    localparam logic signed [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(COORD_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(COORD_MIN);
    localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) <<< (FRAC - 1);

    // Coefficient rows.
    logic [ROW_WIDTH-1:0]       row_reg  [NUM_AXES];
    logic [ROW_WIDTH-1:0]       row_next [NUM_AXES];

    // Multiply stage.
    logic                       s1_valid_reg;
    logic                       s1_final_reg;
    logic signed [PROD_W-1:0]   s1_prod_reg  [NUM_AXES][NUM_LANES];
    logic signed [PROD_W-1:0]   s1_prod_next [NUM_AXES][NUM_LANES];

    // Sum, round and saturate stage.
    logic                       s2_valid_reg;
    logic                       s2_final_reg;
    logic signed [W-1:0]        s2_coord_reg  [NUM_AXES];
    logic signed [W-1:0]        s2_coord_next [NUM_AXES];

    // Running box and result register.
    logic signed [W-1:0]        run_min_reg  [NUM_AXES];
    logic signed [W-1:0]        run_min_next [NUM_AXES];
    logic signed [W-1:0]        run_max_reg  [NUM_AXES];
    logic signed [W-1:0]        run_max_next [NUM_AXES];
    logic signed [W-1:0]        fold_min     [NUM_AXES];
    logic signed [W-1:0]        fold_max     [NUM_AXES];
    logic signed [W-1:0]        box_lo_reg   [NUM_AXES];
    logic signed [W-1:0]        box_hi_reg   [NUM_AXES];
    logic                       box_valid_reg;
    logic                       box_valid_next;

    logic signed [W-1:0]        pos [NUM_LANES];
    logic signed [SUM_W-1:0]    sum_w [NUM_AXES];
    logic signed [SUM_W-1:0]    shr_w [NUM_AXES];
    logic                       advance;
    logic                       fold;

    // The pipeline halts only when a finished box cannot leave the result register.
    assign advance = ~(s2_valid_reg & s2_final_reg & box_valid_reg & box_stall);
    assign fold    = s2_valid_reg & advance;
    assign q_pop   = advance & ~q_status.empty;

    assign cfg_ready = 1'b1;

    // Register writes; an unknown index is dropped.
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            row_next[a] = row_reg[a];
        end
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROW_X: row_next[0] = cfg_data;
                REG_ROW_Y: row_next[1] = cfg_data;
                REG_ROW_Z: row_next[2] = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= IDENT_X;
            row_reg[1] <= IDENT_Y;
            row_reg[2] <= IDENT_Z;
        end
        else
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                row_reg[a] <= row_next[a];
            end
        end
    end

    // Nine independent products of a coefficient lane and a coordinate.
    always_comb
    begin
        pos[0] = $signed(q_data[0 +: W]);
        pos[1] = $signed(q_data[W +: W]);
        pos[2] = $signed(q_data[2*W +: W]);
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                s1_prod_next[a][l] = PROD_W'($signed(row_reg[a][l*CW +: CW]))
                                   * PROD_W'(pos[l]);
            end
        end
    end

    // Sum with translation, round half up, floor, then clamp to the coordinate range.
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            sum_w[a] = SUM_W'(s1_prod_reg[a][0]) + SUM_W'(s1_prod_reg[a][1])
                     + SUM_W'(s1_prod_reg[a][2])
                     + (SUM_W'($signed(row_reg[a][3*CW +: CW])) <<< POS_FRAC)
                     + HALF_LSB;
            shr_w[a] = sum_w[a] >>> FRAC;
            if (shr_w[a] > SAT_HI)
            begin
                s2_coord_next[a] = COORD_MAX;
            end
            else if (shr_w[a] < SAT_LO)
            begin
                s2_coord_next[a] = COORD_MIN;
            end
            else
            begin
                s2_coord_next[a] = shr_w[a][W-1:0];
            end
        end
    end

    // Fold the vertex into the box; a final vertex emits the box and clears it.
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            fold_min[a] = (s2_coord_reg[a] < run_min_reg[a]) ? s2_coord_reg[a] : run_min_reg[a];
            fold_max[a] = (s2_coord_reg[a] > run_max_reg[a]) ? s2_coord_reg[a] : run_max_reg[a];
            run_min_next[a] = run_min_reg[a];
            run_max_next[a] = run_max_reg[a];
            if (fold)
            begin
                run_min_next[a] = s2_final_reg ? COORD_MAX : fold_min[a];
                run_max_next[a] = s2_final_reg ? COORD_MIN : fold_max[a];
            end
        end
        box_valid_next = box_valid_reg;
        if (fold && s2_final_reg)
        begin
            box_valid_next = 1'b1;
        end
        else if (box_valid_reg && !box_stall)
        begin
            box_valid_next = 1'b0;
        end
    end

    // Control and box state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            box_valid_reg <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                run_min_reg[a] <= COORD_MAX;
                run_max_reg[a] <= COORD_MIN;
            end
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg <= ~q_status.empty;
                s2_valid_reg <= s1_valid_reg;
            end
            box_valid_reg <= box_valid_next;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                run_min_reg[a] <= run_min_next[a];
                run_max_reg[a] <= run_max_next[a];
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_final_reg <= q_data[3*W];
            s2_final_reg <= s1_final_reg;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                s2_coord_reg[a] <= s2_coord_next[a];
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    s1_prod_reg[a][l] <= s1_prod_next[a][l];
                end
            end
        end
        if (fold && s2_final_reg)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                box_lo_reg[a] <= fold_min[a];
                box_hi_reg[a] <= fold_max[a];
            end
        end
    end

    assign box_valid = box_valid_reg;
    assign lo_x = box_lo_reg[0];
    assign lo_y = box_lo_reg[1];
    assign lo_z = box_lo_reg[2];
    assign hi_x = box_hi_reg[0];
    assign hi_y = box_hi_reg[1];
    assign hi_z = box_hi_reg[2];

endmodule

`default_nettype wire

// ===== rtl/transformed_point_bounding_box.sv =====
// Channel  Direction  Handshake              Payload
// vtx      in         vtx_valid / vtx_stall  pos_x, pos_y, pos_z, final_vertex
// box      out        box_valid / box_stall  lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Sustains one vertex per cycle while vtx_stall is low; a final vertex's box passes the
// holding register, queue, multiply stage, sum/round stage and box register.
// Reset loads the identity transform and an empty box; cfg_ready is always high.
// box_stall halts the back pipeline only when a second box is ready behind a held one;
// the four-entry queue then fills before vtx_stall rises.
`default_nettype none

module transformed_point_bounding_box #(
    parameter int COORD_WIDTH = 24,
    parameter int COEFF_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                vtx_valid,
    output logic                                vtx_stall,
    input  logic signed [COORD_WIDTH-1:0]       pos_x,
    input  logic signed [COORD_WIDTH-1:0]       pos_y,
    input  logic signed [COORD_WIDTH-1:0]       pos_z,
    input  logic                                final_vertex,
    output logic                                box_valid,
    input  logic                                box_stall,
    output logic signed [COORD_WIDTH-1:0]       lo_x,
    output logic signed [COORD_WIDTH-1:0]       lo_y,
    output logic signed [COORD_WIDTH-1:0]       lo_z,
    output logic signed [COORD_WIDTH-1:0]       hi_x,
    output logic signed [COORD_WIDTH-1:0]       hi_y,
    output logic signed [COORD_WIDTH-1:0]       hi_z,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tpbb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpbb_pkg::ROW_WIDTH-1:0]      cfg_data
);
    import tpbb_pkg::*;

    localparam int DATA_W = 3 * COORD_WIDTH + 1;

    queue_status_t       q_status;
    logic                q_push;
    logic                q_pop;
    logic [DATA_W-1:0]   q_in_data;
    logic [DATA_W-1:0]   q_head_data;

    // Front: takes vertex requests and tags the end of each model.
    tpbb_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .vtx_valid    (vtx_valid),
        .vtx_stall    (vtx_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .final_vertex (final_vertex),
        .q_status     (q_status),
        .q_push       (q_push),
        .q_data       (q_in_data)
    );

    // Queue decoupling the front from the transform pipeline.
    tpbb_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in_data),
        .pop       (q_pop),
        .head_data (q_head_data),
        .status    (q_status)
    );

    // Back: transform, bounds tracking and result register.
    tpbb_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEFF_WIDTH (COEFF_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .q_data    (q_head_data),
        .q_pop     (q_pop),
        .box_valid (box_valid),
        .box_stall (box_stall),
        .lo_x      (lo_x),
        .lo_y      (lo_y),
        .lo_z      (lo_z),
        .hi_x      (hi_x),
        .hi_y      (hi_y),
        .hi_z      (hi_z)
    );

`ifndef SYNTHESIS
    // Every emitted box holds at least one vertex, so it is never inverted.
    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid |-> ($signed(lo_x) <= $signed(hi_x)) && ($signed(lo_y) <= $signed(hi_y))
                      && ($signed(lo_z) <= $signed(hi_z)))
        else $error("emitted box has a minimum above its maximum");

    // The queue cannot report full and empty together.
    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    // The vertex channel stalls only when the queue has no room.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_stall |-> q_status.full && !q_push)
        else $error("vertex request stalled while the queue has room");

    // A request popped from the queue was there to pop.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int CW = 24;
    localparam logic signed [CW-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [CW-1:0] COORD_MIN = 24'sh800000;
    localparam logic [63:0] ROW_X_IDENTITY = 64'h0000_0000_0000_1000;
    localparam logic [63:0] ROW_Y_IDENTITY = 64'h0000_0000_1000_0000;
    localparam logic [63:0] ROW_Z_IDENTITY = 64'h0000_1000_0000_0000;
    localparam logic [tpbb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int RANDOM_VERTICES = 1830;
    localparam int DRAIN_CYCLES = 10;

    // Box layout: index 0..2 are lo_x, lo_y, lo_z; 3..5 are hi_x, hi_y, hi_z.
    typedef logic [5:0][CW-1:0] box_t;

    // Tracks the transform rows and the running box, and holds the boxes still owed.
    class bbox_predictor;
        logic [63:0] row[3];
        logic signed [CW-1:0] run_lo[3];
        logic signed [CW-1:0] run_hi[3];
        box_t expected_boxes[$];
        string field_name[6];
        int errors;
        int boxes_seen;
        int vertices_seen;

        function new();
            row[0] = ROW_X_IDENTITY;
            row[1] = ROW_Y_IDENTITY;
            row[2] = ROW_Z_IDENTITY;
            field_name = '{"lo_x", "lo_y", "lo_z", "hi_x", "hi_y", "hi_z"};
            errors = 0;
            boxes_seen = 0;
            vertices_seen = 0;
            clear_box();
        endfunction

        function void clear_box();
            int a;
            for (a = 0; a < 3; a++)
            begin
                run_lo[a] = COORD_MAX;
                run_hi[a] = COORD_MIN;
            end
        endfunction

        // Affine row applied to one vertex, rounded half up and saturated.
        function logic signed [CW-1:0] apply_row(logic [63:0] r, logic signed [CW-1:0] x,
                                                 logic signed [CW-1:0] y,
                                                 logic signed [CW-1:0] z);
            logic signed [63:0] ca, cb, cc, ct, px, py, pz, acc;
            ca = $signed(r[15:0]);
            cb = $signed(r[31:16]);
            cc = $signed(r[47:32]);
            ct = $signed(r[63:48]);
            px = x;
            py = y;
            pz = z;
            acc = ca * px + cb * py + cc * pz + ct * 64'sd256;
            acc = (acc + 64'sd2048) >>> 12;
            if (acc > 64'sd8388607)
                return COORD_MAX;
            if (acc < -64'sd8388608)
                return COORD_MIN;
            return acc[CW-1:0];
        endfunction

        function void note_config(logic [tpbb_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
            case (idx)
                tpbb_pkg::REG_ROW_X: row[0] = data;
                tpbb_pkg::REG_ROW_Y: row[1] = data;
                tpbb_pkg::REG_ROW_Z: row[2] = data;
                default: ;
            endcase
        endfunction

        // Folds an accepted vertex into the box; the final vertex closes it.
        function void note_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                  logic signed [CW-1:0] z, logic last);
            logic signed [CW-1:0] t;
            box_t closed_box;
            int a;
            for (a = 0; a < 3; a++)
            begin
                t = apply_row(row[a], x, y, z);
                if (t < run_lo[a])
                    run_lo[a] = t;
                if (t > run_hi[a])
                    run_hi[a] = t;
            end
            vertices_seen++;
            if (last)
            begin
                closed_box = {run_hi[2], run_hi[1], run_hi[0],
                              run_lo[2], run_lo[1], run_lo[0]};
                expected_boxes = {expected_boxes, closed_box};
                clear_box();
            end
        endfunction

        function void check_box(box_t got);
            box_t want;
            int i;
            if (expected_boxes.size() == 0)
            begin
                $display("%0t: box arrived with none expected", $time);
                errors++;
                return;
            end
            want = expected_boxes.pop_front();
            boxes_seen++;
            for (i = 0; i < 6; i++)
            begin
                if (got[i] !== want[i])
                begin
                    $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                             field_name[i], $signed(want[i]), $signed(got[i]));
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic vtx_valid;
    logic vtx_stall;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic final_vertex;
    logic box_valid;
    logic box_stall;
    logic signed [CW-1:0] lo_x;
    logic signed [CW-1:0] lo_y;
    logic signed [CW-1:0] lo_z;
    logic signed [CW-1:0] hi_x;
    logic signed [CW-1:0] hi_y;
    logic signed [CW-1:0] hi_z;
    logic cfg_valid;
    logic cfg_ready;
    logic [tpbb_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tpbb_pkg::ROW_WIDTH-1:0] cfg_data;

    bbox_predictor bbox = new();
    int send_idle_pct = 0;
    int stall_pct = 0;
    int configs_written = 0;

    transformed_point_bounding_box i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .vtx_valid    (vtx_valid),
        .vtx_stall    (vtx_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .final_vertex (final_vertex),
        .box_valid    (box_valid),
        .box_stall    (box_stall),
        .lo_x         (lo_x),
        .lo_y         (lo_y),
        .lo_z         (lo_z),
        .hi_x         (hi_x),
        .hi_y         (hi_y),
        .hi_z         (hi_z),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Free-running 100 MHz clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Checks each accepted box, then picks the receiver's stall for the next cycle.
    always @(posedge clk)
    begin : box_monitor
        if (rst_n && box_valid && !box_stall)
            bbox.check_box({hi_z, hi_y, hi_x, lo_z, lo_y, lo_x});
        box_stall <= ($urandom_range(99) < stall_pct);
    end

    // Coordinates: extremes, small values around zero, or any 24-bit pattern.
    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2, 3, 4: return 24'($urandom_range(8192)) - 24'd4096;
            default: return 24'($urandom);
        endcase
    endfunction

    // Transform rows: fully random, saturating extremes, near identity, or small lanes.
    function automatic logic [63:0] rand_row(int axis);
        logic [63:0] r;
        int k;
        r = '0;
        case ($urandom_range(4))
            0: r = {$urandom, $urandom};
            1: r = $urandom_range(1) ? {4{16'h7FFF}} : {4{16'h8000}};
            2:
            begin
                r[16*axis +: 16] = 16'h1000;
                r[63:48] = 16'($urandom);
            end
            default:
            begin
                for (k = 0; k < 4; k++)
                    r[16*k +: 16] = 16'($urandom_range(16384)) - 16'd8192;
            end
        endcase
        return r;
    endfunction

    // Offers one vertex request, with random idle cycles ahead of it.
    task automatic push_vertex(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                               logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            vtx_valid <= 1'b0;
            @(posedge clk);
        end
        vtx_valid <= 1'b1;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        final_vertex <= last;
        @(posedge clk);
        while (vtx_stall)
            @(posedge clk);
        bbox.note_vertex(x, y, z, last);
    endtask

    // Waits until every owed box is out and the pipeline has drained.
    task automatic settle();
        vtx_valid <= 1'b0;
        @(posedge clk);
        while (bbox.expected_boxes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [tpbb_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        bbox.note_config(idx, data);
        configs_written++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // New random transform while idle; sometimes a write to the unused index too.
    task automatic reconfigure();
        settle();
        if ($urandom_range(2) != 0)
            write_reg(tpbb_pkg::REG_ROW_X, rand_row(0));
        if ($urandom_range(2) != 0)
            write_reg(tpbb_pkg::REG_ROW_Y, rand_row(1));
        if ($urandom_range(2) != 0)
            write_reg(tpbb_pkg::REG_ROW_Z, rand_row(2));
        if ($urandom_range(4) == 0)
            write_reg(REG_UNUSED, {$urandom, $urandom});
    endtask

    initial
    begin : stimulus
        int phase;
        int sent;
        int k;
        int mesh_len;

        rst_n <= 1'b0;
        vtx_valid <= 1'b0;
        pos_x <= '0;
        pos_y <= '0;
        pos_z <= '0;
        final_vertex <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 10;
        stall_pct = 72;

        // Identity transform after reset: a one-vertex box, the coordinate extremes, then two bit patterns.
        push_vertex(24'h000000, 24'h000000, 24'h000000, 1'b1);
        push_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        push_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        push_vertex(24'h555555, 24'hAAAAAA, 24'h555555, 1'b0);
        push_vertex(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b1);

        // Saturating rows on x and y; z scales x by one half to probe rounding.
        settle();
        write_reg(tpbb_pkg::REG_ROW_X, {4{16'h7FFF}});
        write_reg(tpbb_pkg::REG_ROW_Y, {4{16'h8000}});
        write_reg(tpbb_pkg::REG_ROW_Z, 64'h0000_0000_0000_0800);
        write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        push_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        push_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        push_vertex(24'd1, 24'd0, 24'd0, 1'b0);
        push_vertex(-24'sd1, 24'd0, 24'd0, 1'b0);
        push_vertex(24'd3, 24'd0, 24'd0, 1'b0);
        push_vertex(-24'sd3, 24'd0, 24'd0, 1'b1);

        // A transform change in the middle of a mesh keeps the box built so far.
        push_vertex(24'd100, 24'd200, 24'd300, 1'b0);
        settle();
        write_reg(tpbb_pkg::REG_ROW_X, ROW_X_IDENTITY);
        write_reg(tpbb_pkg::REG_ROW_Y, ROW_Y_IDENTITY);
        write_reg(tpbb_pkg::REG_ROW_Z, ROW_Z_IDENTITY);
        push_vertex(-24'sd5, 24'd7, 24'd9, 1'b1);

        // Random meshes under three idling patterns.
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 10;
                    stall_pct = 72;
                end
                1:
                begin
                    send_idle_pct = 72;
                    stall_pct = 10;
                end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < RANDOM_VERTICES / 3)
            begin
                reconfigure();
                repeat ($urandom_range(3, 10))
                begin
                    mesh_len = ($urandom_range(9) == 0) ? $urandom_range(9, 40)
                                                        : $urandom_range(1, 6);
                    for (k = 0; k < mesh_len; k++)
                    begin
                        push_vertex(rand_coord(), rand_coord(), rand_coord(),
                                    k == mesh_len - 1);
                        sent++;
                    end
                end
                // Now and then leave a mesh open across the next transform change.
                if ($urandom_range(2) == 0)
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        push_vertex(rand_coord(), rand_coord(), rand_coord(), 1'b0);
                        sent++;
                    end
                end
            end
        end

        settle();
        if (bbox.expected_boxes.size() != 0)
        begin
            $display("%0t: %0d boxes never arrived", $time, bbox.expected_boxes.size());
            bbox.errors++;
        end
        $display("Streamed %0d vertices and checked %0d boxes across %0d register writes,",
                 bbox.vertices_seen, bbox.boxes_seen, configs_written);
        $display("with sender gaps and receiver stalls in both proportions and a gap-free run.");
        if (bbox.errors == 0)
            $display("transformed_point_bounding_box verification clean");
        else
            $display("transformed_point_bounding_box verification failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2000000;
        $display("transformed_point_bounding_box verification failed");
        $finish;
    end

endmodule
